FILE: hw/rtl/clarke_park_transform_macros.svh
// Assertion macros shared by the Clarke/Park transform RTL.
`ifndef CLARKE_PARK_TRANSFORM_MACROS_SVH
`define CLARKE_PARK_TRANSFORM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CPT_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |-> (cons)) \
		else $error("clarke_park_transform: assertion failed");

// Next-cycle implication, checked outside reset.
`define CPT_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |=> (cons)) \
		else $error("clarke_park_transform: assertion failed");

`endif

FILE: hw/rtl/cpt_pkg.sv
// Shared constants and elaboration-time helpers for the Clarke/Park transform.
package cpt_pkg;

	localparam int unsigned CPT_IN_FIELDS  = 7;
	localparam int unsigned CPT_OUT_FIELDS = 6;

	// Integer square root, bit by bit; used at elaboration only.
	function automatic logic [63:0] cpt_isqrt(input logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] probe;
		rem   = x;
		res   = '0;
		probe = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (probe > rem) begin
				probe = probe >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (probe != 64'd0) begin
				if (rem >= res + probe) begin
					rem = rem - (res + probe);
					res = (res >> 1) + probe;
				end else begin
					res = res >> 1;
				end
				probe = probe >> 2;
			end
		end
		return res;
	endfunction

	// round(2^frac / sqrt(3)) = round(sqrt(4^frac / 3))
	function automatic logic [63:0] cpt_inv_sqrt3(input int unsigned frac);
		logic [63:0] x;
		x = (64'd1 << (2 * frac + 2)) / 64'd3;
		return (cpt_isqrt(x) + 64'd1) >> 1;
	endfunction

endpackage

FILE: hw/rtl/cpt_shift_sat.sv
// Arithmetic right shift (floor) followed by signed saturation.
module cpt_shift_sat import cpt_pkg::*; #(
	parameter int unsigned IN_W  = 33,
	parameter int unsigned OUT_W = 16,
	parameter int unsigned SHIFT = 14
) (
	input  logic signed [IN_W-1:0]  din,
	output logic signed [OUT_W-1:0] dout
);

	logic signed [IN_W-1:0]  shifted;
	logic        [IN_W-OUT_W:0] upper;
	logic signed [OUT_W-1:0] max_val;
	logic signed [OUT_W-1:0] min_val;

	assign max_val = {1'b0, {(OUT_W-1){1'b1}}};
	assign min_val = {1'b1, {(OUT_W-1){1'b0}}};

	always_comb begin
		shifted = din >>> SHIFT;
		upper   = shifted[IN_W-1:OUT_W-1];
		// in range when all bits above the result sign agree with it
		if ((&upper) || !(|upper)) begin
			dout = shifted[OUT_W-1:0];
		end else if (shifted[IN_W-1]) begin
			dout = min_val;
		end else begin
			dout = max_val;
		end
	end

endmodule

FILE: hw/rtl/cpt_out_skid.sv
// Output register with a skid entry; upstream ready comes from a flop.
module cpt_out_skid import cpt_pkg::*; #(
	parameter int unsigned DATA_W = 96
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_data
);

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              skid_valid_q;
	logic [DATA_W-1:0] skid_data_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_ready || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_valid;
				end
			end else if (in_valid && !skid_valid_q) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else begin
				out_data_q <= in_data;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_data_q <= in_data;
		end
	end

endmodule

FILE: hw/rtl/clarke_park_transform.sv
// Clarke / Park / inverse Park transform: pipelined fixed-point datapath.
//
// Input stream (s_*): one request per beat carries three phase currents, the sine
// and cosine of the rotor angle and the d/q voltage commands, each SAMPLE_WIDTH
// bits, two's complement, FRACTION_BITS fraction bits.
// Output stream (m_*): one result per request: alpha/beta currents, d/q currents
// and alpha/beta voltages, same format, saturated.
// Throughput: one request per clock, sustained while m_tready stays high.
// An accepted request passes through stages s1, s2, s3, then the output register,
// before it shows on m_tdata.
//   s1: B-C times 1/sqrt3, the four voltage products
//   s2: beta shift/saturate, inverse Park sums
//   s3: the four Park products
//   out: Park sums, shift/saturate, output register with skid entry
// Reset clears all valid bits; no data is held across requests.
// When m_tready is low the stages fill up (up to five requests in flight) and
// s_tready drops; nothing is lost or repeated.
module clarke_park_transform import cpt_pkg::*; #(
	parameter int unsigned SAMPLE_WIDTH  = 16,
	parameter int unsigned FRACTION_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// phase_a_current, phase_b_current, phase_c_current, angle_sine,
	// angle_cosine, d_voltage, q_voltage, zero pad
	input  logic [((CPT_IN_FIELDS*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// alpha_current, beta_current, d_current, q_current, alpha_voltage,
	// beta_voltage, zero pad
	output logic [((CPT_OUT_FIELDS*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata
);

	`include "clarke_park_transform_macros.svh"

	localparam int unsigned W      = SAMPLE_WIDTH;
	localparam int unsigned F      = FRACTION_BITS;
	localparam int unsigned PW     = 2 * W;
	localparam int unsigned BPW    = W + F + 2;
	localparam int unsigned OUT_DW = ((CPT_OUT_FIELDS * SAMPLE_WIDTH + 7) / 8) * 8;
	localparam logic [63:0] K_FULL = cpt_inv_sqrt3(FRACTION_BITS);
	localparam logic signed [F:0] K_COEF = K_FULL[F:0];

	// input fields
	logic signed [W-1:0] in_a, in_b, in_c, in_sin, in_cos, in_ud, in_uq;
	assign in_a   = s_tdata[0*W +: W];
	assign in_b   = s_tdata[1*W +: W];
	assign in_c   = s_tdata[2*W +: W];
	assign in_sin = s_tdata[3*W +: W];
	assign in_cos = s_tdata[4*W +: W];
	assign in_ud  = s_tdata[5*W +: W];
	assign in_uq  = s_tdata[6*W +: W];

	// stage valids and ready chain
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	logic skid_ready;

	assign rdy3     = !v_s3 || skid_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// stage 1
	logic signed [W:0]    diff_bc;
	logic signed [W-1:0]  alpha_s1, sin_s1, cos_s1;
	logic signed [BPW-1:0] beta_prod_s1;
	logic signed [PW-1:0] udc_s1, uqs_s1, uds_s1, uqc_s1;

	assign diff_bc = $signed({in_b[W-1], in_b}) - $signed({in_c[W-1], in_c});

	always_ff @(posedge clk) begin
		if (rdy1) begin
			alpha_s1     <= in_a;
			sin_s1       <= in_sin;
			cos_s1       <= in_cos;
			beta_prod_s1 <= BPW'(diff_bc) * BPW'(K_COEF);
			udc_s1       <= PW'(in_ud) * PW'(in_cos);
			uqs_s1       <= PW'(in_uq) * PW'(in_sin);
			uds_s1       <= PW'(in_ud) * PW'(in_sin);
			uqc_s1       <= PW'(in_uq) * PW'(in_cos);
		end
	end

	// stage 2
	logic signed [PW:0]  ua_sum, ub_sum;
	logic signed [W-1:0] beta_sat, ua_sat, ub_sat;
	logic signed [W-1:0] alpha_s2, beta_s2, sin_s2, cos_s2, ua_s2, ub_s2;

	assign ua_sum = $signed({udc_s1[PW-1], udc_s1}) - $signed({uqs_s1[PW-1], uqs_s1});
	assign ub_sum = $signed({uds_s1[PW-1], uds_s1}) + $signed({uqc_s1[PW-1], uqc_s1});

	cpt_shift_sat #(.IN_W(BPW), .OUT_W(W), .SHIFT(F)) u_sat_beta (
		.din  (beta_prod_s1),
		.dout (beta_sat)
	);

	cpt_shift_sat #(.IN_W(PW + 1), .OUT_W(W), .SHIFT(F)) u_sat_ua (
		.din  (ua_sum),
		.dout (ua_sat)
	);

	cpt_shift_sat #(.IN_W(PW + 1), .OUT_W(W), .SHIFT(F)) u_sat_ub (
		.din  (ub_sum),
		.dout (ub_sat)
	);

	always_ff @(posedge clk) begin
		if (rdy2) begin
			alpha_s2 <= alpha_s1;
			beta_s2  <= beta_sat;
			sin_s2   <= sin_s1;
			cos_s2   <= cos_s1;
			ua_s2    <= ua_sat;
			ub_s2    <= ub_sat;
		end
	end

	// stage 3: Park products on the saturated beta
	logic signed [W-1:0]  alpha_s3, beta_s3, ua_s3, ub_s3;
	logic signed [PW-1:0] ac_s3, bs_s3, as_s3, bc_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			alpha_s3 <= alpha_s2;
			beta_s3  <= beta_s2;
			ua_s3    <= ua_s2;
			ub_s3    <= ub_s2;
			ac_s3    <= PW'(alpha_s2) * PW'(cos_s2);
			bs_s3    <= PW'(beta_s2) * PW'(sin_s2);
			as_s3    <= PW'(alpha_s2) * PW'(sin_s2);
			bc_s3    <= PW'(beta_s2) * PW'(cos_s2);
		end
	end

	// final sums feed the output register
	logic signed [PW:0]  id_sum, iq_sum;
	logic signed [W-1:0] id_sat, iq_sat;
	logic [OUT_DW-1:0]   result_pkt;

	assign id_sum = $signed({ac_s3[PW-1], ac_s3}) + $signed({bs_s3[PW-1], bs_s3});
	assign iq_sum = $signed({bc_s3[PW-1], bc_s3}) - $signed({as_s3[PW-1], as_s3});

	cpt_shift_sat #(.IN_W(PW + 1), .OUT_W(W), .SHIFT(F)) u_sat_id (
		.din  (id_sum),
		.dout (id_sat)
	);

	cpt_shift_sat #(.IN_W(PW + 1), .OUT_W(W), .SHIFT(F)) u_sat_iq (
		.din  (iq_sum),
		.dout (iq_sat)
	);

	always_comb begin
		result_pkt = '0;
		result_pkt[CPT_OUT_FIELDS*W-1:0] = {ub_s3, ua_s3, iq_sat, id_sat, beta_s3, alpha_s3};
	end

	cpt_out_skid #(.DATA_W(OUT_DW)) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (skid_ready),
		.in_data   (result_pkt),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	// input backpressure only when every stage is occupied
	`CPT_ASSERT_NOW(a_stall_full, clk, arst_n, !s_tready, v_s1 && v_s2 && v_s3)
	// an accepted request lands in stage 1
	`CPT_ASSERT_NEXT(a_accept_s1, clk, arst_n, s_tvalid && s_tready, v_s1)
	// a blocked last stage keeps its request
	`CPT_ASSERT_NEXT(a_hold_s3, clk, arst_n, v_s3 && !skid_ready, v_s3)

endmodule

FILE: tb/clarke_park_checker.sv
// Checker for the Clarke/Park transform: watches both streams, predicts and compares.
`timescale 1ns / 1ps

module clarke_park_checker import cpt_pkg::*; #(
	parameter int unsigned IN_W  = ((CPT_IN_FIELDS * 16 + 7) / 8) * 8,
	parameter int unsigned OUT_W = ((CPT_OUT_FIELDS * 16 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	output int               mismatches,
	output int               results_pending
);

	localparam int FRAC = 14;
	// round(2^14 / sqrt(3))
	localparam longint INV_SQRT3 = 9459;

	// alpha_current sits in the lowest bits
	typedef struct packed {
		logic signed [15:0] beta_voltage;
		logic signed [15:0] alpha_voltage;
		logic signed [15:0] q_current;
		logic signed [15:0] d_current;
		logic signed [15:0] beta_current;
		logic signed [15:0] alpha_current;
	} transform_result_t;

	transform_result_t expected_results[$];
	transform_result_t want;
	transform_result_t got;
	int fail_tally = 0;

	function automatic logic signed [15:0] sat16(input longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic transform_result_t clarke_park_result(input logic [IN_W-1:0] req);
		longint ia, ib, ic, sn, cs, vd, vq, beta;
		transform_result_t r;
		ia = $signed(req[15:0]);
		ib = $signed(req[31:16]);
		ic = $signed(req[47:32]);
		sn = $signed(req[63:48]);
		cs = $signed(req[79:64]);
		vd = $signed(req[95:80]);
		vq = $signed(req[111:96]);
		// Park uses beta after saturation; sums are exact in 64 bits, shifts floor
		beta = sat16(((ib - ic) * INV_SQRT3) >>> FRAC);
		r.alpha_current = ia[15:0];
		r.beta_current  = beta[15:0];
		r.d_current     = sat16((ia * cs + beta * sn) >>> FRAC);
		r.q_current     = sat16((beta * cs - ia * sn) >>> FRAC);
		r.alpha_voltage = sat16((vd * cs - vq * sn) >>> FRAC);
		r.beta_voltage  = sat16((vd * sn + vq * cs) >>> FRAC);
		return r;
	endfunction

	function automatic int field_differs(input string name, input logic signed [15:0] exp_v,
			input logic signed [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			results_pending <= 0;
			mismatches <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(clarke_park_result(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					fail_tally++;
				end else begin
					want = expected_results.pop_front();
					got = m_tdata[95:0];
					fail_tally += field_differs("alpha_current", want.alpha_current,
						got.alpha_current);
					fail_tally += field_differs("beta_current", want.beta_current,
						got.beta_current);
					fail_tally += field_differs("d_current", want.d_current, got.d_current);
					fail_tally += field_differs("q_current", want.q_current, got.q_current);
					fail_tally += field_differs("alpha_voltage", want.alpha_voltage,
						got.alpha_voltage);
					fail_tally += field_differs("beta_voltage", want.beta_voltage,
						got.beta_voltage);
				end
			end
			results_pending <= expected_results.size();
			mismatches <= fail_tally;
		end
	end

endmodule

FILE: tb/tb_clarke_park_transform.sv
// Top level testbench for the Clarke/Park transform: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_clarke_park_transform import cpt_pkg::*;;

	localparam int unsigned IN_W  = ((CPT_IN_FIELDS * 16 + 7) / 8) * 8;
	localparam int unsigned OUT_W = ((CPT_OUT_FIELDS * 16 + 7) / 8) * 8;
	localparam int RANDOM_PER_PHASE = 170;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	int mismatches;
	int results_pending;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	clarke_park_transform uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	clarke_park_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatches      (mismatches),
		.results_pending (results_pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	function automatic logic [IN_W-1:0] pack_fields(input shortint ia, input shortint ib,
			input shortint ic, input shortint sn, input shortint cs, input shortint vd,
			input shortint vq);
		return {vq, vd, cs, sn, ic, ib, ia};
	endfunction

	function automatic shortint random_current();
		if ($urandom_range(99) < 30) begin
			return shortint'(int'($urandom_range(4000)) - 2000);
		end
		return shortint'($urandom);
	endfunction

	function automatic logic [IN_W-1:0] random_request();
		real theta;
		int pick;
		shortint sn, cs;
		pick = $urandom_range(99);
		theta = $urandom_range(6283) / 1000.0;
		if (pick < 60) begin
			// point on the unit circle, as a real rotor angle would give
			sn = shortint'($rtoi(16384.0 * $sin(theta)));
			cs = shortint'($rtoi(16384.0 * $cos(theta)));
		end else if (pick < 85) begin
			sn = shortint'(int'($urandom_range(32768)) - 16384);
			cs = shortint'(int'($urandom_range(32768)) - 16384);
		end else begin
			sn = shortint'($urandom);
			cs = shortint'($urandom);
		end
		return pack_fields(random_current(), random_current(), random_current(), sn, cs,
			random_current(), random_current());
	endfunction

	// returns at the edge where the request is taken; valid stays high
	task automatic send_request(input logic [IN_W-1:0] data);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < tx_idle_pct);
		end
		s_tdata <= data;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 27;
		rx_idle_pct = 49;
		send_request(pack_fields(0, 0, 0, 0, 0, 0, 0));
		send_request(pack_fields(32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_request(pack_fields(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
		// beta saturates high and low
		send_request(pack_fields(32767, 32767, -32768, 0, 16384, 32767, -32768));
		send_request(pack_fields(-32768, -32768, 32767, 16384, 0, -32768, 32767));
		send_request(pack_fields(1000, 2000, -3000, -16384, 0, 5000, -7000));
		send_request(pack_fields(-1000, -2000, 3000, 0, -16384, -5000, 7000));
		send_request(pack_fields(32767, 32767, -32768, 16384, 16384, 32767, 32767));
		// sine and cosine beyond +-1.0, sums close to the 32-bit signed limit
		send_request(pack_fields(-32768, 32767, -32768, -32768, -32768, -32768, 32767));
		send_request(pack_fields(32767, -32768, 32767, 32767, -32768, 32767, -32768));
		// tiny negative products: floor rounding
		send_request(pack_fields(-1, 0, 1, 1, 1, -1, 1));
		send_request(pack_fields(1, 1, 0, -1, 1, 1, -1));
		send_request(pack_fields(-3, -1, 2, 3, -5, -7, 2));
		send_request(pack_fields(12000, -6000, -6000, 11585, 11585, 9000, -4000));
		send_request(pack_fields(5000, 7000, 7000, -11585, 11585, -9000, 4000));
		send_request(pack_fields(16'sh5555, 16'sh5555, -16'sh5556, 16384, -16384, 32767, 32767));
		send_request(pack_fields(-16'sh5556, -16'sh5556, 16'sh5555, -16384, 16384,
			-32768, -32768));
		send_request(pack_fields(16384, 0, 0, 0, 16384, 16384, 0));
		send_request(pack_fields(0, 16384, 0, 16384, 0, 0, 16384));

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 27;
					rx_idle_pct = 49;
				end
				1: begin
					tx_idle_pct = 49;
					rx_idle_pct = 27;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_request(random_request());
			end
		end
		s_tvalid <= 1'b0;

		while (results_pending != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
